[hw/rtl/b2da_pkg.sv]
`default_nettype none

package b2da_pkg;

    // Operand and BCD shift register geometry
    localparam int VALUE_W = 63;
    localparam int DIGITS  = 19;
    localparam int BCD_W   = 4 * DIGITS;
    localparam int STEP_W  = $clog2(VALUE_W);
    localparam int DCNT_W  = $clog2(DIGITS + 1);
    localparam int CHAR_W  = 6;

    // ASCII '0' prefix: 48 + d for d < 16 is {2'b11, d}
    localparam logic [CHAR_W-5:0] ASCII_ZERO_HI = 2'b11;

    typedef logic [BCD_W-1:0]   t_bcd;
    typedef logic [VALUE_W-1:0] t_value;

endpackage

`default_nettype wire

[hw/rtl/binary_to_decimal_ascii_core.sv]
`default_nettype none

// Channel   Ports                          Handshake
// --------  -----------------------------  --------------------------------
// input     i_value                        taken when start && !busy
// result    o_digit_char, o_last           one cycle each, marked by o_strobe
//
// One transaction runs one double-dabble step per operand bit through the shared
// add-3/shift unit, then scans the BCD digits from the top at one per cycle,
// leading zeros passing without a strobe.
// The final digit strobes in the first cycle that busy is low again.
// Reset is synchronous, active low, and returns the sequencer to idle.
// The receiver cannot stall: digits leave at one per cycle once the first shows.
module binary_to_decimal_ascii_core (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      start,
    input  wire b2da_pkg::t_value    i_value,
    output logic                     busy,
    output logic                     o_strobe,
    output logic [5:0]               o_digit_char,
    output logic                     o_last
);
    import b2da_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step,  n_step;
    logic [DCNT_W-1:0] r_dcnt,  n_dcnt;
    logic              r_seen,  n_seen;
    t_bcd              r_bcd,   n_bcd;
    t_value            r_bin,   n_bin;
    logic              r_strobe, n_strobe;
    logic              r_last,   n_last;
    logic [3:0]        r_digit,  n_digit;

    t_bcd   step_bcd;
    t_value step_bin;
    logic   top_zero;

    b2da_dabble u_dabble (
        .i_bcd (r_bcd),
        .i_bin (r_bin),
        .o_bcd (step_bcd),
        .o_bin (step_bin)
    );

    assign top_zero = (r_bcd[BCD_W-1 -: 4] == 4'd0);

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_dcnt   = r_dcnt;
        n_seen   = r_seen;
        n_bcd    = r_bcd;
        n_bin    = r_bin;
        n_strobe = 1'b0;
        n_last   = 1'b0;
        n_digit  = r_digit;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_CONV;
                    n_step  = '0;
                    n_bcd   = '0;
                    n_bin   = i_value;
                end
            end
            ST_CONV: begin
                n_bcd  = step_bcd;
                n_bin  = step_bin;
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(VALUE_W - 1)) begin
                    n_state = ST_EMIT;
                    n_dcnt  = DCNT_W'(DIGITS);
                    n_seen  = 1'b0;
                end
            end
            ST_EMIT: begin
                // leading zeros pass silently; the units digit always shows
                n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
                n_dcnt = r_dcnt - 1'b1;
                if (!top_zero || r_seen || r_dcnt == DCNT_W'(1)) begin
                    n_strobe = 1'b1;
                    n_seen   = 1'b1;
                    n_digit  = r_bcd[BCD_W-1 -: 4];
                    n_last   = (r_dcnt == DCNT_W'(1));
                end
                if (r_dcnt == DCNT_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= '0;
            r_dcnt   <= '0;
            r_seen   <= 1'b0;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_dcnt   <= n_dcnt;
            r_seen   <= n_seen;
            r_strobe <= n_strobe;
            r_last   <= n_last;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_bcd   <= n_bcd;
        r_bin   <= n_bin;
        r_digit <= n_digit;
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_strobe     = r_strobe;
    assign o_digit_char = {ASCII_ZERO_HI, r_digit};
    assign o_last       = r_last;

endmodule

`default_nettype wire

[hw/rtl/b2da_dabble.sv]
`default_nettype none

// One shift-and-add-3 step of the binary to BCD conversion
module b2da_dabble (
    input  wire b2da_pkg::t_bcd   i_bcd,
    input  wire b2da_pkg::t_value i_bin,
    output b2da_pkg::t_bcd        o_bcd,
    output b2da_pkg::t_value      o_bin
);
    import b2da_pkg::*;

    t_bcd adj;

    // add 3 to every digit of 5 or more, so the shift carries correctly
    always_comb begin
        for (int d = 0; d < DIGITS; d++) begin
            if (i_bcd[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = i_bcd[4*d +: 4] + 4'd3;
            end else begin
                adj[4*d +: 4] = i_bcd[4*d +: 4];
            end
        end
    end

    // shift the next binary bit into the BCD word
    assign o_bcd = {adj[BCD_W-2:0], i_bin[VALUE_W-1]};
    assign o_bin = {i_bin[VALUE_W-2:0], 1'b0};

endmodule

`default_nettype wire

[hw/rtl/b2da_checker.sv]
`default_nettype none

// Port-level checks on the converter
module b2da_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       start,
    input wire       busy,
    input wire       o_strobe,
    input wire [5:0] o_digit_char,
    input wire       o_last
);

    // an accepted transaction makes the block busy
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");

    // conversion steps come before any digit of the new transaction
    a_no_early_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (!o_strobe ##1 !o_strobe))
        else $error("digit strobed during conversion");

    // once digits flow they continue every cycle until the last
    a_digits_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> o_strobe)
        else $error("gap in digit stream");

    // last only marks a strobed digit
    a_last_with_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_strobe)
        else $error("last without strobe");

    // every character is an ASCII decimal digit
    a_ascii_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_digit_char >= 6'd48 && o_digit_char <= 6'd57))
        else $error("character outside '0'..'9'");

endmodule

bind binary_to_decimal_ascii_core b2da_checker u_b2da_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_strobe     (o_strobe),
    .o_digit_char (o_digit_char),
    .o_last       (o_last)
);

`default_nettype wire

[verif/binary_to_decimal_ascii_core_test.sv]
`timescale 1ns / 100ps

module binary_to_decimal_ascii_core_test;

    import b2da_pkg::*;

    localparam int          CLK_HALF    = 4;
    localparam int          RESET_LEN   = 8;
    localparam int          RADIX       = 10;
    localparam logic [5:0]  CHAR_ZERO   = 6'd48;
    localparam int          RANDOM_LEN  = 360;
    localparam int          CALM_TAIL   = 60;
    localparam int          PAUSE_AT    = 150;
    localparam int          DRAIN_LEN   = 120;
    localparam int          STALL_LIMIT = 4000;
    localparam int          NUM_DIR     = 20;

    // One decimal digit as it should leave the core
    typedef struct packed {
        logic [5:0] ch;
        logic       is_last;
    } t_dec_digit;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    t_value     i_value = '0;
    logic       busy;
    logic       o_strobe;
    logic [5:0] o_digit_char;
    logic       o_last;

    t_dec_digit digit_q[$];
    int         mismatch_count = 0;
    int         numbers_sent = 0;
    int         digits_checked = 0;
    int         widest_number = 0;
    int         stall_cycles = 0;

    // Directed table: empty text means the digits come from the predictor
    t_value dir_value [NUM_DIR] = '{
        63'd0,
        63'd1,
        63'd9,
        63'd10,
        63'h7FFF_FFFF_FFFF_FFFF,
        63'd1000000000000000000,
        63'd999999999999999999,
        63'h4000_0000_0000_0000,
        63'd99,
        63'd100,
        63'd12345,
        63'h0000_0000_FFFF_FFFF,
        63'h0000_0001_0000_0000,
        63'h5555_5555_5555_5555,
        63'h2AAA_AAAA_AAAA_AAAA,
        63'h7FFF_FFFF_FFFF_FFFE,
        63'd100000000000000000,
        63'd0,
        63'd7,
        63'd1
    };
    string dir_text [NUM_DIR] = '{
        "0", "1", "9", "10", "9223372036854775807",
        "1000000000000000000", "999999999999999999", "4611686018427387904",
        "", "", "", "", "", "", "", "", "", "0", "", "1"
    };

    binary_to_decimal_ascii_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_value      (i_value),
        .busy         (busy),
        .o_strobe     (o_strobe),
        .o_digit_char (o_digit_char),
        .o_last       (o_last)
    );

    // Clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        mismatch_count++;
    endtask

    // Decimal expansion by repeated division, most significant digit queued first
    task automatic queue_decimal(input t_value v);
        logic [63:0] rem;
        logic [3:0]  rev [DIGITS];
        int          n;
        rem = {1'b0, v};
        n   = 0;
        do begin
            rev[n] = 4'(rem % RADIX);
            rem    = rem / RADIX;
            n++;
        end while (rem != 0 && n < DIGITS);
        for (int k = 0; k < n; k++)
            digit_q.push_back('{CHAR_ZERO + 6'(rev[n-1-k]), k == n - 1});
        if (n > widest_number) widest_number = n;
    endtask

    // Digits typed in by hand for the obvious rows
    task automatic queue_text(input string s);
        byte c;
        for (int k = 0; k < s.len(); k++) begin
            c = s[k];
            digit_q.push_back('{c[5:0], k == s.len() - 1});
        end
        if (s.len() > widest_number) widest_number = s.len();
    endtask

    // Random operand: mix of full-width, scaled, small, decade-edge, low-mask and near-maximum values
    function automatic t_value rand_value();
        logic [63:0] p;
        t_value      v;
        v = t_value'({$urandom, $urandom});
        case ($urandom_range(0, 5))
            0: ;
            1: v = v >> $urandom_range(0, 62);
            2: v = t_value'($urandom_range(0, 999));
            3: begin
                p = 1;
                repeat ($urandom_range(0, 18)) p = p * RADIX;
                v = t_value'(p) - 1 + t_value'($urandom_range(0, 2));
            end
            4: v = (t_value'(1) << $urandom_range(1, 62)) - 1;
            default: v = 63'h7FFF_FFFF_FFFF_FFFF - t_value'($urandom_range(0, 20));
        endcase
        return v;
    endfunction

    // Present one number; with may_idle a random idle gap sometimes comes first, counted once the core is free
    task automatic send_value(input t_value v, input string text, input bit may_idle);
        int gap;
        if (may_idle && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 15);
            @(negedge i_clk);
            start <= 1'b0;
            while (busy !== 1'b0) @(negedge i_clk);
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start   <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (text.len() != 0) queue_text(text);
        else                 queue_decimal(v);
        numbers_sent++;
    endtask

    // Digit checker
    always @(posedge i_clk) begin
        t_dec_digit want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (digit_q.size() == 0) begin
                report_mismatch($sformatf("digit 0x%0h with nothing pending", o_digit_char));
            end else begin
                want = digit_q.pop_front();
                if (o_digit_char !== want.ch)
                    report_mismatch($sformatf("digit_char 0x%0h, wanted 0x%0h",
                                              o_digit_char, want.ch));
                if (o_last !== want.is_last)
                    report_mismatch($sformatf("last %b, wanted %b", o_last, want.is_last));
                digits_checked++;
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || o_strobe === 1'b1 || (start && busy === 1'b0)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: %0d cycles with no transaction", stall_cycles);
            $display("binary_to_decimal_ascii_core regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Stimulus
    initial begin
        repeat (RESET_LEN) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < NUM_DIR; r++)
            send_value(dir_value[r], dir_text[r], 1'b0);

        for (int i = 0; i < RANDOM_LEN; i++) begin
            if (i == PAUSE_AT) begin
                // let the core drain completely before carrying on
                @(negedge i_clk);
                start <= 1'b0;
                while (digit_q.size() != 0) @(negedge i_clk);
            end
            send_value(rand_value(), "", i < RANDOM_LEN - CALM_TAIL);
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (digit_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_LEN) @(posedge i_clk);

        $display("covered %0d numbers (zero, full width, decade edges, random), %0d digits",
                 numbers_sent, digits_checked);
        $display("widest number %0d digits, %0d mismatches", widest_number, mismatch_count);
        if (mismatch_count == 0 && digit_q.size() == 0)
            $display("binary_to_decimal_ascii_core regression: pass");
        else
            $display("binary_to_decimal_ascii_core regression: fail");
        $finish;
    end

endmodule

[files.f]
hw/rtl/b2da_pkg.sv
hw/rtl/b2da_dabble.sv
hw/rtl/binary_to_decimal_ascii_core.sv
hw/rtl/b2da_checker.sv
verif/binary_to_decimal_ascii_core_test.sv
